// ===== sv/row_ratio_center_filter_defines.svh =====
// ----------------------------------------------------------------------------
// Row ratio center filter: assertion macros
// Shared property forms for the concurrent checks of the filter.
// ----------------------------------------------------------------------------
`ifndef ROW_RATIO_CENTER_FILTER_DEFINES_SVH
`define ROW_RATIO_CENTER_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RRCF_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRCF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rrcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Row ratio center filter package
// Widths, reset values, register codes and the types shared by the modules.
// ----------------------------------------------------------------------------
package rrcf_pkg;

    localparam int PIXEL_W           = 8;
    localparam int VALUE_W           = 16;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int CFG_INDEX_W       = 1;
    localparam int CFG_DATA_W        = 8;
    localparam int WINDOWS           = 3;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [CFG_DATA_W-1:0] VALIDITY_RESET   = 8'd250;
    localparam logic [CFG_DATA_W-1:0] DIFFERENCE_RESET = 8'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VALIDITY   = 1'b0,
        CFG_DIFFERENCE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] validity;
        logic [CFG_DATA_W-1:0] difference;
    } thresh_t;

    // Five-tap window: far left, left, center, right, far right.
    typedef struct packed {
        logic [PIXEL_W-1:0] fl;
        logic [PIXEL_W-1:0] l;
        logic [PIXEL_W-1:0] c;
        logic [PIXEL_W-1:0] r;
        logic [PIXEL_W-1:0] fr;
    } window_t;

    // One accepted pixel's work: up to three windows, each already classified.
    typedef struct packed {
        window_t [WINDOWS-1:0] win;
        logic [WINDOWS-1:0]    ratio;
        logic [1:0]            last_idx;
        logic                  row_end;
    } task_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_EVAL,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

// ===== sv/rrcf_front.sv =====
// ----------------------------------------------------------------------------
// Row ratio center filter: front end
// Accepts pixels, keeps the row history, builds the mirrored windows that the
// pixel completes and classifies each one as ratio or plain average.
// ----------------------------------------------------------------------------
module rrcf_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rrcf_pkg::PIXEL_W-1:0]      s_tdata,
    input  logic                              s_tlast,
    input  rrcf_pkg::thresh_t                 thresh,
    input  logic                              full,
    output logic                              push,
    output rrcf_pkg::task_t                   push_data
);

    logic [rrcf_pkg::PIXEL_W-1:0] hist_reg [4];
    logic [rrcf_pkg::PIXEL_W-1:0] hist_next [4];
    logic [1:0]                   fill_reg;
    logic [1:0]                   fill_next;
    logic                         accept;
    logic                         has_results;
    rrcf_pkg::window_t            w0;
    rrcf_pkg::window_t            w1;
    rrcf_pkg::window_t            w2;
    logic [rrcf_pkg::PIXEL_W-1:0] px;

    function automatic logic use_ratio(input rrcf_pkg::window_t w,
                                       input rrcf_pkg::thresh_t t);
        logic [rrcf_pkg::PIXEL_W-1:0] diff;
        diff = (w.l > w.r) ? (w.l - w.r) : (w.r - w.l);
        return (w.fl < t.validity) && (w.l < t.validity) && (w.r < t.validity)
            && (w.fr < t.validity) && (diff >= t.difference);
    endfunction

    assign px       = s_tdata;
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;
    // The first two pixels of a row give nothing unless the row ends there.
    assign has_results = fill_reg[1] || s_tlast;
    assign push        = accept && has_results;

    always_comb
    begin
        w0 = '{fl: px, l: px, c: px, r: px, fr: px};
        w1 = w0;
        w2 = w0;
        push_data.last_idx = 2'd0;
        unique case (fill_reg)
            2'd0:
            begin
                push_data.last_idx = 2'd0;
            end
            2'd1:
            begin
                w0 = '{fl: hist_reg[0], l: px, c: hist_reg[0], r: px, fr: hist_reg[0]};
                w1 = '{fl: px, l: hist_reg[0], c: px, r: hist_reg[0], fr: px};
                push_data.last_idx = 2'd1;
            end
            2'd2:
            begin
                w0 = '{fl: px, l: hist_reg[0], c: hist_reg[1], r: hist_reg[0], fr: px};
                w1 = '{fl: hist_reg[0], l: hist_reg[1], c: hist_reg[0], r: px,
                       fr: hist_reg[0]};
                w2 = '{fl: hist_reg[1], l: hist_reg[0], c: px, r: hist_reg[0],
                       fr: hist_reg[1]};
                push_data.last_idx = s_tlast ? 2'd2 : 2'd0;
            end
            2'd3:
            begin
                w0 = '{fl: hist_reg[3], l: hist_reg[2], c: hist_reg[1], r: hist_reg[0],
                       fr: px};
                w1 = '{fl: hist_reg[2], l: hist_reg[1], c: hist_reg[0], r: px,
                       fr: hist_reg[0]};
                w2 = '{fl: hist_reg[1], l: hist_reg[0], c: px, r: hist_reg[0],
                       fr: hist_reg[1]};
                push_data.last_idx = s_tlast ? 2'd2 : 2'd0;
            end
            default:
            begin
                push_data.last_idx = 2'd0;
            end
        endcase
        push_data.win[0]   = w0;
        push_data.win[1]   = w1;
        push_data.win[2]   = w2;
        push_data.ratio[0] = use_ratio(w0, thresh);
        push_data.ratio[1] = use_ratio(w1, thresh);
        push_data.ratio[2] = use_ratio(w2, thresh);
        push_data.row_end  = s_tlast;
    end

    always_comb
    begin
        hist_next = hist_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                fill_next = 2'd0;
            end
            else
            begin
                hist_next[0] = px;
                hist_next[1] = hist_reg[0];
                hist_next[2] = hist_reg[1];
                // Left mirror: column -1 reads column 1 once the row is three wide.
                hist_next[3] = (fill_reg == 2'd2) ? hist_reg[0] : hist_reg[2];
                if (fill_reg != 2'd3)
                begin
                    fill_next = fill_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg <= hist_next;
    end

endmodule

// ===== sv/rrcf_queue.sv =====
// ----------------------------------------------------------------------------
// Row ratio center filter: task queue
// Short first-in first-out queue of window tasks between front and back end.
// ----------------------------------------------------------------------------
module rrcf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rrcf_pkg::task_t push_data,
    output logic            full,
    input  logic            pop,
    output rrcf_pkg::task_t pop_data,
    output logic            empty
);

    localparam int DEPTH = rrcf_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    rrcf_pkg::task_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/rrcf_back.sv =====
// ----------------------------------------------------------------------------
// Row ratio center filter: back end
// Works through the windows of each task: products, clamp test, a serial
// restoring divider for the ratio estimate, and the output register.
// ----------------------------------------------------------------------------
module rrcf_back #(
    parameter int FRACTION_BITS = rrcf_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              empty,
    input  rrcf_pkg::task_t                   pop_data,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rrcf_pkg::VALUE_W-1:0]      m_tdata,
    output logic                              m_tlast,
    output logic [0:0]                        m_tuser
);

    localparam int VW = rrcf_pkg::VALUE_W;
    // Quotient bits: the filtered value stays below 2^(8+FRACTION_BITS).
    localparam int QW = 8 + FRACTION_BITS;
    localparam int CW = $clog2(QW);
    localparam int EW = (10 + FRACTION_BITS > VW) ? 10 + FRACTION_BITS : VW;
    localparam int RW = (QW > VW) ? QW : VW;

    rrcf_pkg::back_state_t state_reg, state_next;
    rrcf_pkg::task_t       task_reg, task_next;
    rrcf_pkg::window_t     win;
    logic [1:0]            idx_reg, idx_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [7:0]            c_reg, c_next;
    logic [9:0]            s_reg, s_next;
    logic [18:0]           top_reg, top_next;
    logic [18:0]           twosc_reg, twosc_next;
    logic [9:0]            avg_reg, avg_next;
    logic                  ratio_reg, ratio_next;
    logic [11:0]           rem_reg, rem_next;
    logic [QW-1:0]         lo_reg, lo_next;
    logic [VW-1:0]         value_reg, value_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VW-1:0]         out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_run_reg, out_run_next;

    logic [8:0]            lr;
    logic [9:0]            s_win;
    logic [16:0]           clr;
    logic [17:0]           sc;
    logic [18:0]           limit;
    logic [19:0]           num;
    logic [11:0]           divisor;
    logic [12:0]           trial;
    logic                  ge;
    logic [RW-1:0]         quot;
    logic                  out_free;
    logic                  is_last;

    // (x * 2^FRACTION_BITS) / 2^sh, low value bits kept.
    function automatic logic [VW-1:0] fix_value(input logic [9:0] x, input logic [1:0] sh);
        logic [EW-1:0] e;
        e = EW'(x) << FRACTION_BITS;
        e = e >> sh;
        return e[VW-1:0];
    endfunction

    assign win      = task_reg.win[idx_reg];
    assign out_free = !out_valid_reg || m_tready;
    assign is_last  = (idx_reg == task_reg.last_idx);

    assign lr      = 9'(win.l) + 9'(win.r);
    assign s_win   = 10'(win.fl) + 10'(win.c) + 10'(win.fr);
    assign clr     = 17'(win.c) * 17'(lr);
    assign sc      = 18'(s_win) * 18'(win.c);
    assign limit   = 19'({s_reg, 9'b0}) - 19'({s_reg, 1'b0});
    assign num     = 20'(twosc_reg) + 20'(top_reg);
    assign divisor = {s_reg, 2'b00};
    assign trial   = {rem_reg, lo_reg[QW-1]};
    assign ge      = (trial >= {1'b0, divisor});

    always_comb
    begin
        state_next     = state_reg;
        task_next      = task_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        c_next         = c_reg;
        s_next         = s_reg;
        top_next       = top_reg;
        twosc_next     = twosc_reg;
        avg_next       = avg_reg;
        ratio_next     = ratio_reg;
        rem_next       = rem_reg;
        lo_next        = lo_reg;
        value_next     = value_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_run_next   = out_run_reg;
        out_valid_next = out_valid_reg && !m_tready;
        pop            = 1'b0;
        quot           = '0;

        unique case (state_reg)
            rrcf_pkg::BK_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    task_next  = pop_data;
                    idx_next   = 2'd0;
                    state_next = rrcf_pkg::BK_PREP;
                end
            end
            rrcf_pkg::BK_PREP:
            begin
                c_next     = win.c;
                s_next     = s_win;
                top_next   = (19'(clr) << 1) + 19'(clr);
                twosc_next = {sc, 1'b0};
                avg_next   = 10'({win.c, 1'b0}) + 10'(win.l) + 10'(win.r);
                ratio_next = task_reg.ratio[idx_reg];
                state_next = rrcf_pkg::BK_EVAL;
            end
            rrcf_pkg::BK_EVAL:
            begin
                if (!ratio_reg)
                begin
                    value_next = fix_value(avg_reg, 2'd2);
                    state_next = rrcf_pkg::BK_OUT;
                end
                else if (s_reg == '0)
                begin
                    // Far sum of zero: estimate is zero.
                    value_next = fix_value(10'(c_reg), 2'd1);
                    state_next = rrcf_pkg::BK_OUT;
                end
                else if (top_reg >= limit)
                begin
                    // Ratio estimate clamps at full scale.
                    value_next = fix_value(10'(c_reg) + 10'd255, 2'd1);
                    state_next = rrcf_pkg::BK_OUT;
                end
                else
                begin
                    rem_next   = num[19:8];
                    lo_next    = QW'(num[7:0]) << FRACTION_BITS;
                    cnt_next   = CW'(QW - 1);
                    state_next = rrcf_pkg::BK_DIV;
                end
            end
            rrcf_pkg::BK_DIV:
            begin
                rem_next = ge ? 12'(trial - {1'b0, divisor}) : trial[11:0];
                lo_next  = {lo_reg[QW-2:0], ge};
                quot     = RW'(lo_next);
                if (cnt_reg == '0)
                begin
                    value_next = quot[VW-1:0];
                    state_next = rrcf_pkg::BK_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            rrcf_pkg::BK_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = value_reg;
                    out_last_next  = task_reg.row_end && is_last;
                    out_run_next   = is_last;
                    if (is_last)
                    begin
                        state_next = rrcf_pkg::BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = rrcf_pkg::BK_PREP;
                    end
                end
            end
            default:
            begin
                state_next = rrcf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrcf_pkg::BK_IDLE;
            idx_reg       <= 2'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg     <= task_next;
        c_reg        <= c_next;
        s_reg        <= s_next;
        top_reg      <= top_next;
        twosc_reg    <= twosc_next;
        avg_reg      <= avg_next;
        ratio_reg    <= ratio_next;
        rem_reg      <= rem_next;
        lo_reg       <= lo_next;
        value_reg    <= value_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_run_reg  <= out_run_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_run_reg;

endmodule

// ===== sv/row_ratio_center_filter.sv =====
// ----------------------------------------------------------------------------
// Row ratio center filter
// Horizontal five-tap center filter with mirrored row ends and a ratio estimate.
// ----------------------------------------------------------------------------
// Pixels enter one per transaction on the slave stream, tlast marking the last
// pixel of a row; each result leaves on the master stream two pixels behind,
// and the row end flushes up to three results. Any pixel that gives no result
// is taken and queues no task. A pixel with results is dequeued in the idle
// state; each result then passes the prep, evaluate and output states, and
// the serial divider after evaluate when the ratio estimate runs. The divider
// retires one quotient bit per cycle and sets the throughput. A two-entry task
// queue lets the input keep accepting while the divider works and a result
// waits in the output register. The user must write thresholds through cfg_we,
// cfg_index, cfg_data only while the block is idle; it does not enforce this.
module row_ratio_center_filter #(
    parameter int FRACTION_BITS = rrcf_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] pixel
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [15:0]                          m_tdata,   // [15:0] center_value
    output logic                                 m_tlast,
    output logic [0:0]                           m_tuser,   // [0] run_last
    input  logic                                 cfg_we,
    input  logic [rrcf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rrcf_pkg::CFG_DATA_W-1:0]      cfg_data
);

`include "row_ratio_center_filter_defines.svh"

    rrcf_pkg::thresh_t thresh_reg, thresh_next;
    rrcf_pkg::task_t   push_data;
    rrcf_pkg::task_t   pop_data;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;

    always_comb
    begin
        thresh_next = thresh_reg;
        if (cfg_we)
        begin
            unique case (rrcf_pkg::cfg_index_t'(cfg_index))
                rrcf_pkg::CFG_VALIDITY:   thresh_next.validity   = cfg_data;
                rrcf_pkg::CFG_DIFFERENCE: thresh_next.difference = cfg_data;
                default:                  thresh_next = thresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.validity   <= rrcf_pkg::VALIDITY_RESET;
            thresh_reg.difference <= rrcf_pkg::DIFFERENCE_RESET;
        end
        else
        begin
            thresh_reg <= thresh_next;
        end
    end

    rrcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .thresh    (thresh_reg),
        .full      (q_full),
        .push      (q_push),
        .push_data (push_data)
    );

    rrcf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    rrcf_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .pop_data (pop_data),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    `RRCF_ASSERT_IMPL(a_no_overflow, q_push, !q_full, "task pushed into a full queue")
    `RRCF_ASSERT_IMPL(a_no_underflow, q_pop, !q_empty, "task popped from an empty queue")
    `RRCF_ASSERT_NEXT(a_pop_spacing, q_pop, !q_pop, "back end popped on consecutive cycles")
    `RRCF_ASSERT_IMPL(a_row_last_run, m_tvalid && m_tlast, m_tuser[0], "row end without run end")

endmodule

// ===== tb/row_ratio_center_filter_tb.sv =====
// ----------------------------------------------------------------------------
// Row ratio center filter testbench
// Streams rows of pixels through the filter under several threshold settings
// and pacing modes. A predictor works out the expected centers for each pixel
// transaction; the monitor checks every result against the oldest one pending.
// ----------------------------------------------------------------------------
module row_ratio_center_filter_tb;

    localparam int FRAC           = rrcf_pkg::FRACTION_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct {
        logic [7:0] pixel;
        logic       row_end;
    } pixel_item_t;

    typedef struct {
        logic [15:0] value;
        logic        row_last;
        logic        run_last;
    } center_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [rrcf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rrcf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor copy of the thresholds and the row history
    logic [7:0] validity_thr = rrcf_pkg::VALIDITY_RESET;
    logic [7:0] difference_thr = rrcf_pkg::DIFFERENCE_RESET;
    logic [7:0] row_history [4];
    int         row_fill = 0;

    pixel_item_t    pending_pixels[$];
    center_result_t expected_centers[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int queued_count = 0;
    int accepted_count = 0;
    int rows_seen = 0;
    int centers_checked = 0;
    int fail_count = 0;
    int stall_cycles = 0;
    int settings_used = 1;

    row_ratio_center_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] filtered_center(input int unsigned fl, input int unsigned l,
                                                    input int unsigned c, input int unsigned r,
                                                    input int unsigned fr);
        int unsigned     diff;
        longint unsigned far_sum;
        longint unsigned top;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        diff = (l > r) ? (l - r) : (r - l);
        if (fl < validity_thr && l < validity_thr && r < validity_thr && fr < validity_thr
            && diff >= difference_thr)
        begin
            far_sum = 64'(c) + 64'(fl) + 64'(fr);
            top = 64'(3) * 64'(c) * (64'(l) + 64'(r));
            if (far_sum == 0)
            begin
                num = 64'(c);
                den = 64'(2);
            end
            else if (top >= 64'(510) * far_sum)
            begin
                // clamp the ratio estimate at full scale
                num = 64'(c) + 64'(255);
                den = 64'(2);
            end
            else
            begin
                num = 64'(2) * far_sum * 64'(c) + top;
                den = 64'(4) * far_sum;
            end
        end
        else
        begin
            num = 64'(2) * 64'(c) + 64'(l) + 64'(r);
            den = 64'(4);
        end
        q = (num << FRAC) / den;
        return q[15:0];
    endfunction

    // Reflect a column index into a row of n pixels
    function automatic int reflect_col(input int j, input int n);
        int idx;
        int i;
        if (n <= 1)
            return 0;
        idx = j;
        for (i = 0; i < 4; i++)
        begin
            if (idx < 0)
                idx = -idx;
            else if (idx >= n)
                idx = 2 * (n - 1) - idx;
        end
        if (idx < 0)
            idx = 0;
        if (idx >= n)
            idx = n - 1;
        return idx;
    endfunction

    function automatic center_result_t make_result(input logic [15:0] value,
                                                   input logic row_last);
        center_result_t res;
        res.value = value;
        res.row_last = row_last;
        res.run_last = 1'b0;
        return res;
    endfunction

    task automatic predict_centers(input logic [7:0] px, input logic row_end);
        int unsigned    a [3];
        center_result_t outs [3];
        int             n;
        int             k;
        int             i;
        int             col;
        int             last;
        int unsigned    b0;
        int unsigned    b1;
        int unsigned    b2;
        int unsigned    b3;
        n = 0;
        if (row_fill < 3)
        begin
            k = row_fill;
            a[k] = 32'(px);
            for (i = 1; i <= k; i++)
                a[k - i] = 32'(row_history[i - 1]);
            if (row_end)
                last = k;
            else if (k == 2)
                last = 0;
            else
                last = -1;
            for (col = 0; col <= last; col++)
            begin
                outs[n] = make_result(filtered_center(a[reflect_col(col - 2, k + 1)],
                                                      a[reflect_col(col - 1, k + 1)],
                                                      a[col],
                                                      a[reflect_col(col + 1, k + 1)],
                                                      a[reflect_col(col + 2, k + 1)]),
                                      row_end && col == last);
                n++;
            end
        end
        else
        begin
            b0 = 32'(row_history[3]);
            b1 = 32'(row_history[2]);
            b2 = 32'(row_history[1]);
            b3 = 32'(row_history[0]);
            outs[n] = make_result(filtered_center(b0, b1, b2, b3, 32'(px)), 1'b0);
            n++;
            if (row_end)
            begin
                outs[n] = make_result(filtered_center(b1, b2, b3, 32'(px), b3), 1'b0);
                n++;
                outs[n] = make_result(filtered_center(b2, b3, 32'(px), b3, b2), 1'b1);
                n++;
            end
        end
        if (n > 0)
            outs[n - 1].run_last = 1'b1;
        for (i = 0; i < n; i++)
            expected_centers.push_back(outs[i]);

        if (row_end)
        begin
            for (i = 0; i < 4; i++)
                row_history[i] = '0;
            row_fill = 0;
        end
        else
        begin
            row_history[3] = row_history[2];
            row_history[2] = row_history[1];
            row_history[1] = row_history[0];
            row_history[0] = px;
            // left mirror: column -1 reads column 1
            if (row_fill == 2)
                row_history[3] = row_history[1];
            if (row_fill < 3)
                row_fill++;
        end
    endtask

    // Driver: hold each pixel until its transaction completes
    always @(posedge clk)
    begin : drive_pixels
        pixel_item_t item;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                accepted_count++;
                if (s_tlast)
                    rows_seen++;
                predict_centers(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item = pending_pixels.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= item.pixel;
                    s_tlast <= item.row_end;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : check_centers
        center_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                centers_checked++;
                if (expected_centers.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: expected no result, got %0d last %0b run %0b",
                             $time, m_tdata, m_tlast, m_tuser[0]);
                end
                else
                begin
                    want = expected_centers.pop_front();
                    if (m_tdata !== want.value)
                    begin
                        fail_count++;
                        $display("%0t: center_value expected %0d got %0d",
                                 $time, want.value, m_tdata);
                    end
                    if (m_tlast !== want.row_last)
                    begin
                        fail_count++;
                        $display("%0t: row_last expected %0b got %0b",
                                 $time, want.row_last, m_tlast);
                    end
                    if (m_tuser[0] !== want.run_last)
                    begin
                        fail_count++;
                        $display("%0t: run_last expected %0b got %0b",
                                 $time, want.run_last, m_tuser[0]);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, expected_centers.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic queue_pixel(input int px, input bit row_end);
        pixel_item_t item;
        item.pixel = px[7:0];
        item.row_end = row_end;
        pending_pixels.push_back(item);
        queued_count++;
    endtask

    function automatic int pick_pixel(input int style);
        int v;
        case (style)
            1: v = $urandom_range(0, 7);
            2:
            begin
                v = int'(validity_thr) + int'($urandom_range(0, 3)) - 2;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
            end
            3: v = $urandom_range(0, 1) ? $urandom_range(230, 255) : $urandom_range(0, 25);
            default: v = $urandom_range(0, 255);
        endcase
        return v;
    endfunction

    // Queue whole rows, mostly short, until about n_items pixels are pending
    task automatic queue_rows(input int n_items);
        int added;
        int len;
        int style;
        int j;
        added = 0;
        while (added < n_items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            style = $urandom_range(0, 3);
            for (j = 0; j < len; j++)
            begin
                // mix in a stray full-range pixel now and then
                if ($urandom_range(0, 7) == 0)
                    queue_pixel($urandom_range(0, 255), j == len - 1);
                else
                    queue_pixel(pick_pixel(style), j == len - 1);
            end
            added += len;
        end
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_count || expected_centers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_thresholds(input logic [7:0] validity, input logic [7:0] difference);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= rrcf_pkg::CFG_VALIDITY;
        cfg_data <= validity;
        @(posedge clk);
        cfg_index <= rrcf_pkg::CFG_DIFFERENCE;
        cfg_data <= difference;
        @(posedge clk);
        cfg_we <= 1'b0;
        validity_thr = validity;
        difference_thr = difference;
        settings_used++;
    endtask

    initial
    begin
        for (int i = 0; i < 4; i++)
            row_history[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 30;
        recv_idle_pct = 78;

        // One-pixel and two-pixel rows
        queue_pixel(255, 1'b1);
        queue_pixel(0, 1'b0);
        queue_pixel(255, 1'b1);
        // Three-pixel row
        queue_pixel(10, 1'b0);
        queue_pixel(200, 1'b0);
        queue_pixel(30, 1'b1);
        // Zero far sum at column 2
        queue_pixel(0, 1'b0);
        queue_pixel(9, 1'b0);
        queue_pixel(0, 1'b0);
        queue_pixel(1, 1'b0);
        queue_pixel(0, 1'b1);
        // Ratio estimate clamped at full scale at column 2
        queue_pixel(0, 1'b0);
        queue_pixel(249, 1'b0);
        queue_pixel(200, 1'b0);
        queue_pixel(0, 1'b0);
        queue_pixel(0, 1'b1);
        // Invalid neighbours and a mixed longer row
        queue_pixel(255, 1'b0);
        queue_pixel(128, 1'b0);
        queue_pixel(255, 1'b0);
        queue_pixel(1, 1'b0);
        queue_pixel(250, 1'b0);
        queue_pixel(249, 1'b0);
        queue_pixel(127, 1'b1);
        wait_idle();

        write_thresholds(8'd255, 8'd0);
        queue_rows(45);
        wait_idle();

        write_thresholds(8'd0, 8'd255);
        queue_rows(35);
        wait_idle();

        send_idle_pct = 78;
        recv_idle_pct = 30;
        write_thresholds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 40)));
        queue_rows(40);
        wait_idle();

        write_thresholds(8'd128, 8'd0);
        queue_rows(40);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_thresholds(8'd255, 8'd255);
        queue_rows(30);
        wait_idle();

        write_thresholds(rrcf_pkg::VALIDITY_RESET, rrcf_pkg::DIFFERENCE_RESET);
        queue_rows(45);
        wait_idle();

        $display("Summary: %0d pixels in %0d rows, %0d filtered centers compared",
                 accepted_count, rows_seen, centers_checked);
        $display("Summary: %0d threshold settings, three pacing modes, %0d mismatches",
                 settings_used, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
